// ===== rtl/modular_exponentiation_defines.svh =====
// assertion macros shared by the modular exponentiation rtl
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// condition in this cycle implies property in this cycle
`define MEXP_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("mexp: assertion failed");

// condition in this cycle implies property in the next cycle
`define MEXP_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("mexp: assertion failed");

`endif

// ===== rtl/mexp_pkg.sv =====
// constants, microcode format and program of the modular exponentiation block
package mexp_pkg;

    localparam int BASE_W   = 30;
    localparam int EXP_BITS = 30;
    localparam int POW_W    = 30;
    localparam int MW       = 32;
    localparam int PC_W     = 5;
    localparam int CNT_W    = $clog2(EXP_BITS + 1);

    localparam logic [POW_W-1:0] PRIME = 30'd1000000007;

    // montgomery constants, radix 2^MW
    localparam logic [63:0] R_MOD64 = (64'd1 << MW) % 64'd1000000007;
    localparam logic [63:0] R2_64   = (R_MOD64 * R_MOD64) % 64'd1000000007;
    localparam logic [POW_W-1:0] MONT_ONE = R_MOD64[POW_W-1:0];
    localparam logic [POW_W-1:0] MONT_R2  = R2_64[POW_W-1:0];

    // -n^-1 mod 2^MW by newton iteration
    function automatic logic [MW-1:0] mont_ninv(input logic [MW-1:0] n);
        logic [MW-1:0] inv;
        inv = n;
        for (int i = 0; i < 5; i++)
        begin
            inv = inv * (MW'(2) - n * inv);
        end
        return MW'(0) - inv;
    endfunction

    localparam logic [MW-1:0] NINV = mont_ninv({{(MW - POW_W){1'b0}}, PRIME});

    // multiplier operand selection
    typedef logic [2:0] mul_sel_t;
    localparam mul_sel_t MS_BASE_R2 = 3'd0;
    localparam mul_sel_t MS_ACC_SQ  = 3'd1;
    localparam mul_sel_t MS_SQ_SQ   = 3'd2;
    localparam mul_sel_t MS_ACC_ONE = 3'd3;
    localparam mul_sel_t MS_LO_NINV = 3'd4;
    localparam mul_sel_t MS_M_N     = 3'd5;

    // product destination
    typedef logic [1:0] dst_t;
    localparam dst_t DST_NONE = 2'd0;
    localparam dst_t DST_PROD = 2'd1;
    localparam dst_t DST_M    = 2'd2;
    localparam dst_t DST_MN   = 2'd3;

    // reduction write-back
    typedef logic [1:0] wb_t;
    localparam wb_t WB_NONE = 2'd0;
    localparam wb_t WB_SQ   = 2'd1;
    localparam wb_t WB_ACC  = 2'd2;
    localparam wb_t WB_OUT  = 2'd3;

    // sequencing
    typedef logic [1:0] jmp_t;
    localparam jmp_t JMP_NONE    = 2'd0;
    localparam jmp_t JMP_BIT_CLR = 2'd1;
    localparam jmp_t JMP_LOOP    = 2'd2;
    localparam jmp_t JMP_END     = 2'd3;

    typedef logic [PC_W-1:0] pc_t;
    localparam pc_t PC_START  = 5'd0;
    localparam pc_t PC_LOOP   = 5'd4;
    localparam pc_t PC_SQUARE = 5'd9;
    localparam pc_t PC_FINISH = 5'd13;

    typedef struct packed {
        mul_sel_t mul_sel;
        dst_t     dst;
        wb_t      wb;
        jmp_t     jmp;
        pc_t      target;
    } ucode_word_t;

    function automatic ucode_word_t uw(input mul_sel_t ms, input dst_t dst, input wb_t wb,
                                       input jmp_t jmp, input pc_t target);
        ucode_word_t w;
        w.mul_sel = ms;
        w.dst     = dst;
        w.wb      = wb;
        w.jmp     = jmp;
        w.target  = target;
        return w;
    endfunction

    // program: convert base, loop over exponent bits, convert result back
    function automatic ucode_word_t ucode_rom(input pc_t pc);
        ucode_word_t w;
        unique case (pc)
            5'd0:    w = uw(MS_BASE_R2, DST_PROD, WB_NONE, JMP_NONE,    PC_START);
            5'd1:    w = uw(MS_LO_NINV, DST_M,    WB_NONE, JMP_NONE,    PC_START);
            5'd2:    w = uw(MS_M_N,     DST_MN,   WB_NONE, JMP_NONE,    PC_START);
            5'd3:    w = uw(MS_M_N,     DST_NONE, WB_SQ,   JMP_NONE,    PC_START);
            5'd4:    w = uw(MS_M_N,     DST_NONE, WB_NONE, JMP_BIT_CLR, PC_SQUARE);
            5'd5:    w = uw(MS_ACC_SQ,  DST_PROD, WB_NONE, JMP_NONE,    PC_START);
            5'd6:    w = uw(MS_LO_NINV, DST_M,    WB_NONE, JMP_NONE,    PC_START);
            5'd7:    w = uw(MS_M_N,     DST_MN,   WB_NONE, JMP_NONE,    PC_START);
            5'd8:    w = uw(MS_M_N,     DST_NONE, WB_ACC,  JMP_NONE,    PC_START);
            5'd9:    w = uw(MS_SQ_SQ,   DST_PROD, WB_NONE, JMP_NONE,    PC_START);
            5'd10:   w = uw(MS_LO_NINV, DST_M,    WB_NONE, JMP_NONE,    PC_START);
            5'd11:   w = uw(MS_M_N,     DST_MN,   WB_NONE, JMP_NONE,    PC_START);
            5'd12:   w = uw(MS_M_N,     DST_NONE, WB_SQ,   JMP_LOOP,    PC_LOOP);
            5'd13:   w = uw(MS_ACC_ONE, DST_PROD, WB_NONE, JMP_NONE,    PC_START);
            5'd14:   w = uw(MS_LO_NINV, DST_M,    WB_NONE, JMP_NONE,    PC_START);
            5'd15:   w = uw(MS_M_N,     DST_MN,   WB_NONE, JMP_NONE,    PC_START);
            5'd16:   w = uw(MS_M_N,     DST_NONE, WB_OUT,  JMP_END,     PC_START);
            default: w = uw(MS_M_N,     DST_NONE, WB_NONE, JMP_END,     PC_START);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/mexp_in_if.sv =====
// operand channel: base and exponent with valid/ready
interface mexp_in_if;
    logic                            valid;
    logic                            ready;
    logic [mexp_pkg::BASE_W-1:0]     base;
    logic [mexp_pkg::EXP_BITS-1:0]   exponent;

    modport source (output valid, output base, output exponent, input ready);
    modport sink (input valid, input base, input exponent, output ready);
endinterface

// ===== rtl/mexp_out_if.sv =====
// result channel: power with valid/ready
interface mexp_out_if;
    logic                         valid;
    logic                         ready;
    logic [mexp_pkg::POW_W-1:0]   power;

    modport source (output valid, output power, input ready);
    modport sink (input valid, input power, output ready);
endinterface

// ===== rtl/modular_exponentiation.sv =====
// Computes base^exponent mod 1000000007 by right-to-left square-and-multiply in the
// Montgomery domain (radix 2^32). One item is worked at a time: after the operand transfer
// the block runs its microcode steps, four more of them for each set exponent bit, and its
// last step waits until the previous result is taken; every step is one pass through
// the single shared 32x32 multiplier or the reduction adder, and each exponent bit costs a
// squaring plus, when set, a multiply. The next operand is taken as soon as the result is
// loaded into the output register, even while that result still waits to be taken. An
// exponent of zero gives 1, and a base of 1000000007 or more is reduced exactly.
`include "modular_exponentiation_defines.svh"

module modular_exponentiation (
    input  logic        clk,
    input  logic        rst_n,
    mexp_in_if.sink     operand,
    mexp_out_if.source  result
);

    logic                                busy_reg, busy_next;
    mexp_pkg::pc_t                       pc_reg, pc_next;
    logic [mexp_pkg::CNT_W-1:0]          cnt_reg;
    logic                                out_valid_reg, out_valid_next;

    logic [mexp_pkg::BASE_W-1:0]         base_reg;
    logic [mexp_pkg::EXP_BITS-1:0]       exp_reg;
    logic [mexp_pkg::POW_W-1:0]          acc_reg;
    logic [mexp_pkg::POW_W-1:0]          sq_reg;
    logic [59:0]                         prod_reg;
    logic [mexp_pkg::MW-1:0]             m_reg;
    logic [61:0]                         mn_reg;
    logic [mexp_pkg::POW_W-1:0]          power_reg;

    mexp_pkg::ucode_word_t               word;
    logic [mexp_pkg::MW-1:0]             mul_a;
    logic [mexp_pkg::MW-1:0]             mul_b;
    logic [2*mexp_pkg::MW-1:0]           mul_p;
    logic [30:0]                         red_sum;
    logic [30:0]                         red_sub;
    logic [mexp_pkg::POW_W-1:0]          red_val;
    logic                                accept;
    logic                                stall;
    logic                                step;

    assign word   = mexp_pkg::ucode_rom(pc_reg);
    assign accept = operand.valid && !busy_reg;
    assign stall  = (word.wb == mexp_pkg::WB_OUT) && out_valid_reg && !result.ready;
    assign step   = busy_reg && !stall;

    assign operand.ready = !busy_reg;
    assign result.valid  = out_valid_reg;
    assign result.power  = power_reg;

    // shared multiplier
    always_comb
    begin
        unique case (word.mul_sel)
            mexp_pkg::MS_BASE_R2:
            begin
                mul_a = {2'b00, base_reg};
                mul_b = {2'b00, mexp_pkg::MONT_R2};
            end
            mexp_pkg::MS_ACC_SQ:
            begin
                mul_a = {2'b00, acc_reg};
                mul_b = {2'b00, sq_reg};
            end
            mexp_pkg::MS_SQ_SQ:
            begin
                mul_a = {2'b00, sq_reg};
                mul_b = {2'b00, sq_reg};
            end
            mexp_pkg::MS_ACC_ONE:
            begin
                mul_a = {2'b00, acc_reg};
                mul_b = 32'd1;
            end
            mexp_pkg::MS_LO_NINV:
            begin
                mul_a = prod_reg[31:0];
                mul_b = mexp_pkg::NINV;
            end
            mexp_pkg::MS_M_N:
            begin
                mul_a = m_reg;
                mul_b = {2'b00, mexp_pkg::PRIME};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // (t + m*n) / 2^32: low halves sum to zero or exactly 2^32
    assign red_sum = {3'b000, prod_reg[59:32]} + {1'b0, mn_reg[61:32]}
                   + {30'd0, |prod_reg[31:0]};
    assign red_sub = red_sum - {1'b0, mexp_pkg::PRIME};
    assign red_val = (red_sum >= {1'b0, mexp_pkg::PRIME}) ? red_sub[29:0] : red_sum[29:0];

    // sequencer
    always_comb
    begin
        pc_next = pc_reg;
        if (!busy_reg)
        begin
            pc_next = mexp_pkg::PC_START;
        end
        else if (step)
        begin
            unique case (word.jmp)
                mexp_pkg::JMP_NONE:    pc_next = pc_reg + 5'd1;
                mexp_pkg::JMP_BIT_CLR: pc_next = exp_reg[0] ? pc_reg + 5'd1 : word.target;
                mexp_pkg::JMP_LOOP:
                    pc_next = (cnt_reg != mexp_pkg::CNT_W'(1)) ? word.target : pc_reg + 5'd1;
                mexp_pkg::JMP_END:     pc_next = mexp_pkg::PC_START;
                default:               pc_next = mexp_pkg::PC_START;
            endcase
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (step && word.jmp == mexp_pkg::JMP_END)
        begin
            busy_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step && word.wb == mexp_pkg::WB_OUT)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= mexp_pkg::PC_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            base_reg <= operand.base;
            exp_reg  <= operand.exponent;
            cnt_reg  <= mexp_pkg::CNT_W'(mexp_pkg::EXP_BITS);
            acc_reg  <= mexp_pkg::MONT_ONE;
        end
        else if (step)
        begin
            unique case (word.dst)
                mexp_pkg::DST_PROD: prod_reg <= mul_p[59:0];
                mexp_pkg::DST_M:    m_reg    <= mul_p[31:0];
                mexp_pkg::DST_MN:   mn_reg   <= mul_p[61:0];
                default:            ;
            endcase
            unique case (word.wb)
                mexp_pkg::WB_SQ:  sq_reg    <= red_val;
                mexp_pkg::WB_ACC: acc_reg   <= red_val;
                mexp_pkg::WB_OUT: power_reg <= red_val;
                default:          ;
            endcase
            if (word.jmp == mexp_pkg::JMP_LOOP)
            begin
                exp_reg <= exp_reg >> 1;
                cnt_reg <= cnt_reg - mexp_pkg::CNT_W'(1);
            end
        end
    end

    `MEXP_ASSERT_NOW(a_idle_pc_home, !busy_reg, pc_reg == mexp_pkg::PC_START)
    `MEXP_ASSERT_NEXT(a_accept_starts, accept, busy_reg && pc_reg == mexp_pkg::PC_START)
    `MEXP_ASSERT_NOW(a_loop_reduced, busy_reg && pc_reg == mexp_pkg::PC_LOOP,
                     acc_reg < mexp_pkg::PRIME && sq_reg < mexp_pkg::PRIME)
    `MEXP_ASSERT_NOW(a_loop_count, busy_reg && pc_reg == mexp_pkg::PC_LOOP, cnt_reg != '0)
    `MEXP_ASSERT_NEXT(a_result_loaded, step && word.wb == mexp_pkg::WB_OUT,
                      out_valid_reg && !busy_reg && power_reg < mexp_pkg::PRIME)

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the modular exponentiation block: directed and random operands
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BASE_W = mexp_pkg::BASE_W;
    localparam int EXP_W  = mexp_pkg::EXP_BITS;
    localparam int POW_W  = mexp_pkg::POW_W;
    localparam longint unsigned MODULUS = 64'd1000000007;
    localparam int RANDOM_ITEMS = 1950;
    localparam int SETTLE_CYCLES = 300;
    localparam longint CYCLE_LIMIT = 64'd4000000;

    class power_scoreboard;
        logic [POW_W-1:0] expected_powers[$];
        int operands_seen;
        int powers_checked;
        int zero_exponents;
        int unreduced_bases;
        int errors;

        function logic [POW_W-1:0] mod_power(logic [BASE_W-1:0] b, logic [EXP_W-1:0] e);
            longint unsigned sq;
            longint unsigned acc;
            sq  = longint'(b) % MODULUS;
            acc = 1;
            for (int i = 0; i < EXP_W; i++)
            begin
                if (e[i])
                    acc = (acc * sq) % MODULUS;
                sq = (sq * sq) % MODULUS;
            end
            return acc[POW_W-1:0];
        endfunction

        function void note_operand(logic [BASE_W-1:0] b, logic [EXP_W-1:0] e);
            expected_powers.push_back(mod_power(b, e));
            operands_seen++;
            if (e == '0)
                zero_exponents++;
            if (longint'(b) >= MODULUS)
                unreduced_bases++;
        endfunction

        function void check_power(logic [POW_W-1:0] actual);
            logic [POW_W-1:0] expected;
            if (expected_powers.size() == 0)
            begin
                $error("power: unexpected result %0d with nothing outstanding", actual);
                errors++;
                return;
            end
            expected = expected_powers.pop_front();
            powers_checked++;
            if (actual !== expected)
            begin
                $error("power mismatch: expected %0d, actual %0d", expected, actual);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_powers.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   steady;
    longint cycle_count;
    power_scoreboard sb;

    mexp_in_if  operand_if();
    mexp_out_if result_if();

    modular_exponentiation DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .operand(operand_if),
        .result (result_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        if (r < 98)
            return $urandom_range(5, 20);
        return $urandom_range(40, 120);
    endfunction

    // monitor both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (operand_if.valid && operand_if.ready)
                sb.note_operand(operand_if.base, operand_if.exponent);
            if (result_if.valid && result_if.ready)
                sb.check_power(result_if.power);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.outstanding());
            $display("modular_exponentiation regression: fail");
            $finish;
        end
    end

    // result side backpressure
    initial
    begin
        int stall;
        int burst;
        result_if.ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = pick_gap();
            burst = $urandom_range(1, 12);
            if (stall > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            repeat (burst) @(posedge clk);
        end
    end

    task automatic send_operand(input logic [BASE_W-1:0] b, input logic [EXP_W-1:0] e);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            operand_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operand_if.valid    <= 1'b1;
        operand_if.base     <= b;
        operand_if.exponent <= e;
        do
            @(posedge clk);
        while (!operand_if.ready);
    endtask

    task automatic drain_results();
        operand_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic random_operand(output logic [BASE_W-1:0] b, output logic [EXP_W-1:0] e);
        int rb;
        int re;
        rb = $urandom_range(0, 99);
        re = $urandom_range(0, 99);
        if (rb < 70)
            b = BASE_W'($urandom_range(0, MODULUS - 1));
        else if (rb < 80)
            b = BASE_W'($urandom_range(MODULUS, (1 << BASE_W) - 1));
        else if (rb < 88)
            b = BASE_W'($urandom_range(0, 3));
        else if (rb < 94)
            b = BASE_W'(MODULUS - 1 - $urandom_range(0, 3));
        else
            b = BASE_W'($urandom());
        if (re < 60)
            e = EXP_W'($urandom());
        else if (re < 72)
            e = EXP_W'($urandom_range(0, 16));
        else if (re < 80)
            e = EXP_W'(1) << $urandom_range(0, EXP_W - 1);
        else if (re < 88)
            e = ~(EXP_W'(1) << $urandom_range(0, EXP_W - 1));
        else if (re < 94)
            e = EXP_W'($urandom() & $urandom() & $urandom());
        else
            e = EXP_W'($urandom() | $urandom());
    endtask

    initial
    begin
        logic [BASE_W-1:0] b;
        logic [EXP_W-1:0]  e;
        logic [BASE_W-1:0] dir_base[$];
        logic [EXP_W-1:0]  dir_exp[$];
        int directed_count;

        sb = new();
        cycle_count = 0;
        steady = 1'b0;
        rst_n = 1'b0;
        operand_if.valid    = 1'b0;
        operand_if.base     = '0;
        operand_if.exponent = '0;

        // zero exponent, zero base, extremes of both fields
        dir_base = {30'd0, 30'd5, 30'd0, 30'd0, 30'd1, 30'd1000000006, 30'd1000000006,
                    30'd1000000006, 30'h3FFFFFFF, 30'h3FFFFFFF, 30'd1000000007,
                    30'd1000000008, 30'd2, 30'd2, 30'd2, 30'd3, 30'd123456789,
                    30'd987654321, 30'h3FFFFFFF, 30'd1000000006};
        dir_exp  = {30'd0, 30'd0, 30'd1, 30'h3FFFFFFF, 30'h3FFFFFFF, 30'd1, 30'd2,
                    30'h3FFFFFFF, 30'h3FFFFFFF, 30'd1, 30'd5, 30'h3FFFFFFF, 30'd29,
                    30'h20000000, 30'd1000000006, 30'd1000000005, 30'h2AAAAAAA,
                    30'h15555555, 30'd0, 30'd0};
        directed_count = dir_base.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < directed_count; i++)
            send_operand(dir_base[i], dir_exp[i]);
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // one stretch with no idling on either side
            steady = (i >= 600 && i < 800);
            if (i == 1000)
                drain_results();
            random_operand(b, e);
            send_operand(b, e);
        end
        steady = 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.outstanding() != 0)
        begin
            $error("power: %0d expected results never arrived", sb.outstanding());
            sb.errors++;
        end
        $display("covered %0d operand transfers (%0d directed), %0d powers checked",
                 sb.operands_seen, directed_count, sb.powers_checked);
        $display("including %0d zero exponents and %0d unreduced bases, %0d errors",
                 sb.zero_exponents, sb.unreduced_bases, sb.errors);
        if (sb.errors == 0)
            $display("modular_exponentiation regression: pass");
        else
            $display("modular_exponentiation regression: fail");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/mexp_pkg.sv
rtl/mexp_in_if.sv
rtl/mexp_out_if.sv
rtl/modular_exponentiation.sv
test/testbench.sv
